/* rtl/core/pn2d_pkg.sv */
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants, the hash and the quarter-wave sine table for the 2D noise.
// ----------------------------------------------------------------------------
`default_nettype none
package pn2d_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Floor quotient by shift and subtract; numerators stay below 2^41
  function automatic longint unsigned div_small(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = n;
    for (int b = 40; b >= 0; b--) begin
      if ((d << b) <= rem) begin
        rem = rem - (d << b);
        quo = quo | (64'd1 << b);
      end
    end
    return quo;
  endfunction

  // Q1.15 sine of (pi/2) * j / 2^jbits, integer Taylor series, evaluated at elaboration
  function automatic logic [15:0] quarter_sine(input int unsigned j, input int unsigned jbits);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint sum;
    longint unsigned r;
    int unsigned k;
    t = (longint'(j) * HALF_PI_Q30 + ((64'd1 << jbits) >> 1)) >> jbits;
    t2 = (t * t) >> 30;
    term = t;
    sum = longint'(t);
    for (k = 1; k <= 6; k++) begin
      term = (term * t2) >> 30;
      term = div_small(term, longint'((2 * k) * (2 * k + 1)));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/perlin_noise_2d.sv */
// ----------------------------------------------------------------------------
// perlin_noise_2d
// Fixed-point 2D gradient noise: hash, gradient lookup, dot products, lerps.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction | handshake
//  point   | start, x_coord_i, y_coord_i       | in        | start && !busy
//  noise   | done_o, noise_value_o           | out       | done_o, one cycle
//
//  done_o follows each transfer through the valid shift register; one point per cycle.
//  The stage count is set by the corner stage, the three chained hash
//  multiplies, each its own stage, then lookup, dot, two lerp stages,
//  rounding and saturation.
//  busy is always low and the pipe never stalls: the receiver must take every result; the block does not enforce it.
//  Reset clears the valid bits only; payload registers are not reset.
`default_nettype none
module perlin_noise_2d #(
  parameter int unsigned ANGLE_BITS = pn2d_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [31:0] x_coord_i,
  input  wire logic signed [31:0] y_coord_i,
  output      logic               done_o,
  output      logic signed [17:0] noise_value_o
);

  localparam int unsigned QS = 1 << (ANGLE_BITS - 2);
  localparam int unsigned JB = ANGLE_BITS - 2;
  localparam logic [JB:0] QS_IDX = {1'b1, {JB{1'b0}}};
  localparam logic [15:0] FMASK = 16'hFFFF & ~((16'd1 << (16 - FRAC_BITS)) - 16'd1);
  localparam int NS = 10;
  localparam int FD = 7;

  // quarter sine table, entries 0..QS
  logic [15:0] sin_tab [QS+1];
  always_comb begin
    for (int i = 0; i <= int'(QS); i++) sin_tab[i] = pn2d_pkg::quarter_sine(unsigned'(i), JB);
  end

  assign busy = 1'b0;

  logic [NS-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], start};
    end
  end

  // stage 1: corners and fractions
  logic [31:0] ca_q [4];
  logic [31:0] cb_q [4];
  logic [16:0] fx_q [FD];
  logic [16:0] fy_q [FD];
  always_ff @(posedge clk_i) begin
    ca_q[0] <= {{16{x_coord_i[31]}}, x_coord_i[31:16]};
    ca_q[1] <= {{16{x_coord_i[31]}}, x_coord_i[31:16]} + 32'd1;
    ca_q[2] <= {{16{x_coord_i[31]}}, x_coord_i[31:16]};
    ca_q[3] <= {{16{x_coord_i[31]}}, x_coord_i[31:16]} + 32'd1;
    cb_q[0] <= {{16{y_coord_i[31]}}, y_coord_i[31:16]};
    cb_q[1] <= {{16{y_coord_i[31]}}, y_coord_i[31:16]};
    cb_q[2] <= {{16{y_coord_i[31]}}, y_coord_i[31:16]} + 32'd1;
    cb_q[3] <= {{16{y_coord_i[31]}}, y_coord_i[31:16]} + 32'd1;
    fx_q[0] <= {1'b0, x_coord_i[15:0] & FMASK};
    fy_q[0] <= {1'b0, y_coord_i[15:0] & FMASK};
    for (int s = 1; s < FD; s++) begin
      fx_q[s] <= fx_q[s-1];
      fy_q[s] <= fy_q[s-1];
    end
  end

  // stages 2-4: hash, one multiply per stage
  logic [31:0] ha_q [4];
  logic [31:0] hb_q [4];
  logic [31:0] hc_q [4];
  logic [31:0] hd_q [4];
  logic [31:0] he_q [4];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      ha_q[c] <= ca_q[c] * pn2d_pkg::HASH_K1;
      hb_q[c] <= cb_q[c];
      hc_q[c] <= (hb_q[c] ^ {ha_q[c][15:0], ha_q[c][31:16]}) * pn2d_pkg::HASH_K2;
      hd_q[c] <= ha_q[c];
      he_q[c] <= (hd_q[c] ^ {hc_q[c][15:0], hc_q[c][31:16]}) * pn2d_pkg::HASH_K3;
    end
  end

  // stage 5: gradient lookup
  logic signed [16:0] gx_q [4];
  logic signed [16:0] gy_q [4];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      logic [ANGLE_BITS-1:0] idx;
      logic [JB-1:0] jj;
      logic [JB:0] jc;
      logic signed [16:0] sj, sc;
      idx = he_q[c][31 -: ANGLE_BITS];
      jj  = idx[JB-1:0];
      jc  = QS_IDX - {1'b0, jj};
      sj  = $signed({1'b0, sin_tab[{1'b0, jj}]});
      sc  = $signed({1'b0, sin_tab[jc]});
      case (idx[ANGLE_BITS-1 -: 2])
        2'd0:    begin gx_q[c] <= sc;  gy_q[c] <= sj;  end
        2'd1:    begin gx_q[c] <= -sj; gy_q[c] <= sc;  end
        2'd2:    begin gx_q[c] <= -sc; gy_q[c] <= -sj; end
        default: begin gx_q[c] <= sj;  gy_q[c] <= -sc; end
      endcase
    end
  end

  // stage 6: dot products
  logic signed [35:0] n_q [4];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      logic signed [17:0] dx, dy;
      dx = $signed({1'b0, fx_q[4]}) - (c[0] ? 18'sd65536 : 18'sd0);
      dy = $signed({1'b0, fy_q[4]}) - ((c >= 2) ? 18'sd65536 : 18'sd0);
      n_q[c] <= 36'(dx * gx_q[c]) + 36'(dy * gy_q[c]);
    end
  end

  // stage 7: lerp along x
  logic signed [36:0] ix0_q, ix1_q;
  always_ff @(posedge clk_i) begin
    logic signed [55:0] p0, p1;
    p0 = 56'(n_q[1] - n_q[0]) * $signed({1'b0, fx_q[5]});
    p1 = 56'(n_q[3] - n_q[2]) * $signed({1'b0, fx_q[5]});
    ix0_q <= 37'(n_q[0]) + 37'(p0 >>> 16);
    ix1_q <= 37'(n_q[2]) + 37'(p1 >>> 16);
  end

  // stage 8: lerp along y
  logic signed [37:0] v_q;
  always_ff @(posedge clk_i) begin
    logic signed [57:0] p;
    p = 58'(ix1_q - ix0_q) * $signed({1'b0, fy_q[6]});
    v_q <= 38'(ix0_q) + 38'(p >>> 16);
  end

  // stage 9: round to Q.16
  logic signed [23:0] r_q;
  always_ff @(posedge clk_i) begin
    logic signed [38:0] t;
    t = 39'(v_q) + 39'sd16384;
    r_q <= 24'(t >>> 15);
  end

  // stage 10: saturate
  always_ff @(posedge clk_i) begin
    if (r_q > 24'(pn2d_pkg::OUT_MAX))      noise_value_o <= 18'(pn2d_pkg::OUT_MAX);
    else if (r_q < 24'(pn2d_pkg::OUT_MIN)) noise_value_o <= 18'(pn2d_pkg::OUT_MIN);
    else                                   noise_value_o <= r_q[17:0];
  end

  assign done_o = vld_q[NS-1];

endmodule
`default_nettype wire

/* rtl/core/pn2d_checker.sv */
// ----------------------------------------------------------------------------
// pn2d_checker
// Port-level checks on the noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pn2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [17:0] noise_value_o
);

  // every transfer yields a result
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##10 done_o) else $error("missing result");

  // no result without a matching earlier transfer
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 10)) else $error("spurious result");

  // the block never pushes back
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  // a strobed result carries known bits
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(noise_value_o)) else $error("unknown result");

endmodule

bind perlin_noise_2d pn2d_checker u_pn2d_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .noise_value_o(noise_value_o)
);
`default_nettype wire

/* tb/sv/perlin_noise_2d_checker.sv */
// ----------------------------------------------------------------------------
// perlin_noise_2d_checker
// Watches the point and noise channels, computes the expected noise value of
// every accepted point and compares it with each result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module perlin_noise_2d_checker #(
  parameter int unsigned ANGLE_BITS = pn2d_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic signed [31:0] x_coord_i,
  input  wire logic signed [31:0] y_coord_i,
  input  wire logic               done_i,
  input  wire logic signed [17:0] noise_value_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam int unsigned QSTEPS = 1 << (ANGLE_BITS - 2);
  localparam logic [15:0] FRAC_MASK = 16'hFFFF & ~((16'd1 << (16 - FRAC_BITS)) - 16'd1);

  logic signed [17:0] noise_q[$];
  longint             sine_lut[QSTEPS + 1];

  // Q1.15 sine by truncated Taylor series in Q2.30
  function automatic longint sine_q15(int unsigned j);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint          acc;
    longint unsigned r;
    t = (64'(j) * 64'd1686629713 + 64'(QSTEPS >> 1)) / 64'(QSTEPS);
    t2 = (t * t) >> 30;
    term = t;
    acc = longint'(t);
    for (int k = 1; k <= 6; k++) begin
      term = (term * t2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (64'(acc) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return longint'(r);
  endfunction

  function automatic logic [31:0] rot_half(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] mix_corner(logic [31:0] a, logic [31:0] b);
    a = a * pn2d_pkg::HASH_K1;
    b = b ^ rot_half(a);
    b = b * pn2d_pkg::HASH_K2;
    a = a ^ rot_half(b);
    a = a * pn2d_pkg::HASH_K3;
    return a;
  endfunction

  function automatic longint floor_div16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
                                          longint dx, longint dy);
    logic [31:0] h;
    int unsigned idx;
    int unsigned quad;
    int unsigned j;
    longint      sj;
    longint      sc;
    longint      gx;
    longint      gy;
    h = mix_corner(cx, cy);
    idx = h >> (32 - ANGLE_BITS);
    quad = (idx >> (ANGLE_BITS - 2)) & 3;
    j = idx & (QSTEPS - 1);
    sj = sine_lut[j];
    sc = sine_lut[QSTEPS - j];
    case (quad)
      0: begin gx = sc;  gy = sj;  end
      1: begin gx = -sj; gy = sc;  end
      2: begin gx = -sc; gy = -sj; end
      default: begin gx = sj; gy = -sc; end
    endcase
    return dx * gx + dy * gy;
  endfunction

  function automatic logic signed [17:0] noise_at(logic [31:0] ux, logic [31:0] uy);
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] x1;
    logic [31:0] y1;
    longint      fx;
    longint      fy;
    longint      n0;
    longint      n1;
    longint      ix0;
    longint      ix1;
    longint      v;
    x0 = {{16{ux[31]}}, ux[31:16]};
    y0 = {{16{uy[31]}}, uy[31:16]};
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    fx = longint'(ux[15:0] & FRAC_MASK);
    fy = longint'(uy[15:0] & FRAC_MASK);
    n0 = gradient_dot(x0, y0, fx, fy);
    n1 = gradient_dot(x1, y0, fx - 65536, fy);
    ix0 = n0 + floor_div16((n1 - n0) * fx);
    n0 = gradient_dot(x0, y1, fx, fy - 65536);
    n1 = gradient_dot(x1, y1, fx - 65536, fy - 65536);
    ix1 = n0 + floor_div16((n1 - n0) * fx);
    v = ix0 + floor_div16((ix1 - ix0) * fy);
    v = (v + 16384) >>> 15;
    if (v > pn2d_pkg::OUT_MAX) v = pn2d_pkg::OUT_MAX;
    if (v < pn2d_pkg::OUT_MIN) v = pn2d_pkg::OUT_MIN;
    return v[17:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    for (int j = 0; j <= QSTEPS; j++) sine_lut[j] = sine_q15(j);
  end

  assign pending_o = noise_q.size();

  // Queue each point transfer, then check each strobed result
  always @(posedge clk_i) begin
    logic signed [17:0] want;
    if (rst_ni) begin
      if (start_i && !busy_i) noise_q.push_back(noise_at(x_coord_i, y_coord_i));
      if (done_i) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("noise_value %0d with no point waiting", noise_value_i));
        end else begin
          want = noise_q.pop_front();
          checked_o++;
          if (noise_value_i !== want)
            report_mismatch($sformatf("noise_value got %0d want %0d", noise_value_i, want));
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/perlin_noise_2d_test.sv */
// ----------------------------------------------------------------------------
// perlin_noise_2d_test
// Drives directed and random points into the noise block under varying idle
// patterns; the checker beside it predicts and compares every noise value.
// ----------------------------------------------------------------------------
`default_nettype none
module perlin_noise_2d_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 1950;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] x_coord_i = '0;
  logic signed [31:0] y_coord_i = '0;
  logic               done_o;
  logic signed [17:0] noise_value_o;
  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 cycle_count = 0;
  int                 sent = 0;

  perlin_noise_2d u_top (
    .clk_i, .rst_ni, .start, .busy, .x_coord_i, .y_coord_i, .done_o, .noise_value_o
  );

  perlin_noise_2d_checker u_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .x_coord_i, .y_coord_i,
    .done_i(done_o), .noise_value_i(noise_value_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one point and hold it until its transfer
  task automatic send_point(logic [31:0] x, logic [31:0] y, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Full-range, mid-range, small and near-extreme coordinates with random fractions
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {{8{1'($urandom_range(1))}}, 8'($urandom()), 16'($urandom())};
      2: return {16'($urandom_range(3) - 2), 16'($urandom())};
      default: return {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8];
    edge_vals = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_0000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0001};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, top-cell wrap, integer points, half points
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[(i + 3) % 8], 0);
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[i], 0);
    send_point(32'h5555_AAAA, 32'hAAAA_5555, 0);
    send_point(32'h0000_FFFF, 32'hFFFF_0000, 0);

    // Hold off until the pipe drains
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++)
      send_point(pick_coord(), pick_coord(), i < N_RANDOM / 3 ? 10 :
                 (i < 2 * N_RANDOM / 3 ? 77 : 0));
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Covered %0d points (directed extremes and random), %0d noise values checked.",
             sent, checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
